// ----- rtl/core/otap_pkg.sv -----
// Shared types and constants for the ownership table access policy block.
package otap_pkg;

   localparam int OPCODE_W  = 2;
   localparam int INDEX_W   = 12;
   localparam int THREAD_W  = 6;
   localparam int MODE_W    = 2;
   localparam int VERDICT_W = 3;
   localparam int ENTRY_W   = THREAD_W + 1;
   localparam int REQ_W     = 24;
   localparam int RSP_W     = 24;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_LOAD    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_STORE   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_COMMIT  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd3;

   // Run modes; the fourth code behaves as serial
   localparam logic [MODE_W-1:0] RM_OWNERSHIP = 2'd0;
   localparam logic [MODE_W-1:0] RM_BUFFERED  = 2'd1;

   // Verdicts
   localparam logic [VERDICT_W-1:0] V_DIRECT = 3'd0;
   localparam logic [VERDICT_W-1:0] V_BLOCK  = 3'd1;
   localparam logic [VERDICT_W-1:0] V_BUFFER = 3'd2;
   localparam logic [VERDICT_W-1:0] V_SERIAL = 3'd3;
   localparam logic [VERDICT_W-1:0] V_COMMIT = 3'd4;

   // Table entry: shared flag on top, owner below
   localparam logic [ENTRY_W-1:0] SHARED_ENTRY = 7'h40;

   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic mul_en;
      logic mod_en;
      logic rd_en;
      logic upd;
   } otap_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
   } otap_sts_type;

endpackage

// ----- rtl/core/otap_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module otap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/otap_ctrl.sv -----
// Controller state machine: table clear sweep, then one request at a time.
module otap_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output otap_pkg::otap_cmd_type cmd,
   input  otap_pkg::otap_sts_type sts
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_MOD   = 3'd3;
   localparam logic [2:0] S_READ  = 3'd4;
   localparam logic [2:0] S_UPD   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
            if (req_tvalid) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_MOD;
         end
         S_MOD: begin
            cmd.mod_en = 1'b1;
            state_in   = S_READ;
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_UPD;
         end
         S_UPD: begin
            // hold the read entry until the result register can take it
            if (sts.out_free) begin
               cmd.upd  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/core/otap_dp.sv -----
// Datapath: index reduction, owner table, policy decision and result register.
module otap_dp #(
   parameter int TABLE_ENTRIES = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  otap_pkg::otap_cmd_type           cmd,
   output otap_pkg::otap_sts_type           sts,
   input  logic [otap_pkg::REQ_W-1:0]       req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [otap_pkg::RSP_W-1:0]       rsp_tdata
);

   localparam int ADDR_W  = $clog2(TABLE_ENTRIES);
   localparam int SHIFT   = otap_pkg::INDEX_W + ADDR_W;
   localparam int RECIP_W = otap_pkg::INDEX_W + 2;
   localparam int PROD_W  = otap_pkg::INDEX_W + RECIP_W;
   localparam int REM_W   = otap_pkg::INDEX_W + ADDR_W + 1;
   // ceil(2^SHIFT / TABLE_ENTRIES): exact quotient for every 12-bit index
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << SHIFT)
      + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES));
   localparam logic [REM_W-1:0] TE_WIDE = REM_W'(TABLE_ENTRIES);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_ENTRIES - 1);

   // request fields
   logic [otap_pkg::OPCODE_W-1:0] opcode_ff;
   logic [otap_pkg::INDEX_W-1:0]  index_ff;
   logic [otap_pkg::THREAD_W-1:0] thread_ff;
   logic [otap_pkg::MODE_W-1:0]   mode_ff;
   logic                          several_ff;
   logic                          sole_ff;

   logic [PROD_W-1:0]             prod_ff;
   logic [otap_pkg::INDEX_W-1:0]  quot;
   logic [REM_W-1:0]              rem_wide;
   logic [ADDR_W-1:0]             addr_ff;
   logic [ADDR_W-1:0]             clr_cnt_ff;
   logic [ADDR_W-1:0]             clr_cnt_in;

   logic                          ram_wr_en;
   logic [ADDR_W-1:0]             ram_wr_addr;
   logic [otap_pkg::ENTRY_W-1:0]  ram_wr_data;
   logic [otap_pkg::ENTRY_W-1:0]  prior;

   logic                           shared;
   logic                           mine;
   logic                           foreign;
   logic [otap_pkg::ENTRY_W-1:0]   next;
   logic [otap_pkg::VERDICT_W-1:0] verdict;
   logic [otap_pkg::RSP_W-1:0]     rsp_data_in;
   logic [otap_pkg::RSP_W-1:0]     rsp_data_ff;
   logic                           rsp_valid_in;
   logic                           rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         opcode_ff  <= req_tdata[1:0];
         index_ff   <= req_tdata[13:2];
         thread_ff  <= req_tdata[19:14];
         mode_ff    <= req_tdata[21:20];
         several_ff <= req_tdata[22];
         sole_ff    <= req_tdata[23];
      end
      if (cmd.mul_en) begin
         prod_ff <= PROD_W'(index_ff) * PROD_W'(RECIP);
      end
      if (cmd.mod_en) begin
         addr_ff <= rem_wide[ADDR_W-1:0];
      end
   end

   assign quot     = otap_pkg::INDEX_W'(prod_ff >> SHIFT);
   assign rem_wide = REM_W'(index_ff) - REM_W'(quot) * TE_WIDE;

   // clear sweep counter
   assign clr_cnt_in     = cmd.clear_wr ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
   assign sts.clear_last = (clr_cnt_ff == LAST_ADDR);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   assign ram_wr_en   = cmd.clear_wr | cmd.upd;
   assign ram_wr_addr = cmd.clear_wr ? clr_cnt_ff : addr_ff;
   assign ram_wr_data = cmd.clear_wr ? otap_pkg::SHARED_ENTRY : next;

   otap_ram #(
      .WIDTH (otap_pkg::ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (addr_ff),
      .rd_data (prior)
   );

   // access policy
   always_comb begin
      shared  = prior[otap_pkg::ENTRY_W-1];
      mine    = !shared && (prior[otap_pkg::THREAD_W-1:0] == thread_ff);
      foreign = !shared && !mine;
      next    = prior;
      verdict = otap_pkg::V_COMMIT;
      case (opcode_ff)
         otap_pkg::OP_LOAD: begin
            if (mode_ff == otap_pkg::RM_OWNERSHIP) begin
               verdict = (shared || mine) ? otap_pkg::V_DIRECT : otap_pkg::V_BLOCK;
            end else if (mode_ff == otap_pkg::RM_BUFFERED) begin
               verdict = otap_pkg::V_BUFFER;
            end else begin
               verdict = otap_pkg::V_SERIAL;
               if (foreign) begin
                  next = otap_pkg::SHARED_ENTRY;
               end
            end
         end
         otap_pkg::OP_STORE: begin
            if (mode_ff == otap_pkg::RM_OWNERSHIP) begin
               verdict = mine ? otap_pkg::V_DIRECT : otap_pkg::V_BLOCK;
            end else if (mode_ff == otap_pkg::RM_BUFFERED) begin
               verdict = otap_pkg::V_BUFFER;
            end else begin
               verdict = otap_pkg::V_SERIAL;
               if (!mine) begin
                  next = several_ff ? {1'b0, thread_ff} : otap_pkg::SHARED_ENTRY;
               end
            end
         end
         otap_pkg::OP_COMMIT: begin
            if (several_ff && sole_ff) begin
               next = {1'b0, thread_ff};
            end
         end
         otap_pkg::OP_RELEASE: begin
            if (several_ff && foreign) begin
               next = otap_pkg::SHARED_ENTRY;
            end
         end
         default: begin
            next = prior;
         end
      endcase
   end

   // result: verdict, prior shared/owner, new shared/owner, zero pad
   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in[2:0]   = verdict;
      rsp_data_in[3]     = shared;
      rsp_data_in[9:4]   = shared ? '0 : prior[otap_pkg::THREAD_W-1:0];
      rsp_data_in[10]    = next[otap_pkg::ENTRY_W-1];
      rsp_data_in[16:11] = next[otap_pkg::ENTRY_W-1] ? '0 : next[otap_pkg::THREAD_W-1:0];
   end

   assign rsp_valid_in = cmd.upd | (rsp_valid_ff & ~rsp_tready);
   assign sts.out_free = ~rsp_valid_ff | rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.upd) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/core/ownership_table_access_policy.sv -----
// Ownership table access policy: top level joining controller and datapath.
//
// Input stream req_*: one transfer per access check (load, store, commit,
// read-log release). Output stream rsp_*: one transfer per request with the
// verdict and the table entry before and after the request.
// Each request is handled alone: after the input transfer the index is
// reduced modulo TABLE_ENTRIES (multiply stage, remainder stage), the entry
// is read from the owner table RAM, then decided and written back. The
// result becomes valid and req_tready is high again in the same cycle, at
// the write-back, so a new request is taken only after the one before it
// has been written back; the two index reduction stages, the registered
// table read and the write-back lie between a request and its result.
// The result sits in an output register: when the receiver stalls, the
// next request is still taken and runs up to its write-back, where it waits
// until the output register frees.
// Reset (synchronous, active high) starts a clearing pass that writes every
// table entry shared, one entry per cycle; no request is taken during the
// pass.
module ownership_table_access_policy #(
   parameter int TABLE_ENTRIES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // opcode[1:0], entry_index[13:2], thread_id[19:14], run_mode[21:20],
   // several_threads[22], sole_writer[23]
   input  logic [23:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // verdict[2:0], prior_shared[3], prior_owner[9:4], new_shared[10],
   // new_owner[16:11], zero [23:17]
   output logic [23:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready
);

   otap_pkg::otap_cmd_type cmd;
   otap_pkg::otap_sts_type sts;

   otap_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   otap_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTHESIS
   a_no_req_in_clear : assert property (@(posedge clock) disable iff (reset)
      cmd.clear_wr |-> !req_tready)
      else $error("request ready during table clear");

   a_one_at_a_time : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second request taken while one is in flight");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.upd |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten while stalled");

   a_result_shown : assert property (@(posedge clock) disable iff (reset)
      cmd.upd |=> rsp_tvalid)
      else $error("write-back without a result");
`endif

endmodule

// ----- dv/owner_table_checker.sv -----
// Checker: predicts owner table verdicts from request transfers and compares response transfers.
`timescale 1ns / 1ps
module owner_table_checker #(
   parameter int TABLE_ENTRIES = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [otap_pkg::REQ_W-1:0] req_tdata,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [otap_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output int                         failures,
   output int                         outstanding
);

   // verdict in the low bits, new_owner on top, as on rsp_tdata
   typedef struct packed {
      logic [otap_pkg::THREAD_W-1:0]  new_owner;
      logic                           new_shared;
      logic [otap_pkg::THREAD_W-1:0]  prior_owner;
      logic                           prior_shared;
      logic [otap_pkg::VERDICT_W-1:0] verdict;
   } access_outcome_type;

   localparam int OUTCOME_W = $bits(access_outcome_type);

   logic [otap_pkg::ENTRY_W-1:0] owner_map [TABLE_ENTRIES];
   access_outcome_type           awaited_outcomes [$];

   always @(posedge clock) begin : track
      logic [otap_pkg::OPCODE_W-1:0] op;
      int unsigned                   line;
      logic [otap_pkg::THREAD_W-1:0] tid;
      logic [otap_pkg::MODE_W-1:0]   mode;
      logic                          several, sole;
      logic [otap_pkg::ENTRY_W-1:0]  prior, next;
      logic                          is_shared, is_mine, is_foreign;
      access_outcome_type            want, got;
      if (reset) begin
         foreach (owner_map[i]) owner_map[i] = otap_pkg::SHARED_ENTRY;
         awaited_outcomes.delete();
      end else begin
         // responses first: a request taken at this edge cannot answer at it
         if (rsp_tvalid && rsp_tready) begin
            got = access_outcome_type'(rsp_tdata[OUTCOME_W-1:0]);
            if (awaited_outcomes.size() == 0) begin
               $error("response transfer with nothing awaited: %h", rsp_tdata);
               failures++;
            end else begin
               want = awaited_outcomes.pop_front();
               if (got.verdict !== want.verdict) begin
                  $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
                  failures++;
               end
               if (got.prior_shared !== want.prior_shared) begin
                  $error("prior_shared: expected %0d, got %0d",
                         want.prior_shared, got.prior_shared);
                  failures++;
               end
               if (got.prior_owner !== want.prior_owner) begin
                  $error("prior_owner: expected %0d, got %0d",
                         want.prior_owner, got.prior_owner);
                  failures++;
               end
               if (got.new_shared !== want.new_shared) begin
                  $error("new_shared: expected %0d, got %0d", want.new_shared, got.new_shared);
                  failures++;
               end
               if (got.new_owner !== want.new_owner) begin
                  $error("new_owner: expected %0d, got %0d", want.new_owner, got.new_owner);
                  failures++;
               end
               if (rsp_tdata[otap_pkg::RSP_W-1:OUTCOME_W] !== '0) begin
                  $error("padding: expected 0, got %h",
                         rsp_tdata[otap_pkg::RSP_W-1:OUTCOME_W]);
                  failures++;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            op      = req_tdata[1:0];
            line    = int'(req_tdata[13:2]) % TABLE_ENTRIES;
            tid     = req_tdata[19:14];
            mode    = req_tdata[21:20];
            several = req_tdata[22];
            sole    = req_tdata[23];

            prior      = owner_map[line];
            is_shared  = prior[otap_pkg::THREAD_W];
            is_mine    = !is_shared && prior[otap_pkg::THREAD_W-1:0] == tid;
            is_foreign = !is_shared && !is_mine;
            next       = prior;

            case (op)
               otap_pkg::OP_LOAD, otap_pkg::OP_STORE: begin
                  case (mode)
                     otap_pkg::RM_OWNERSHIP: begin
                        want.verdict = ((op == otap_pkg::OP_LOAD && is_shared) || is_mine) ?
                                       otap_pkg::V_DIRECT : otap_pkg::V_BLOCK;
                     end
                     otap_pkg::RM_BUFFERED: begin
                        want.verdict = otap_pkg::V_BUFFER;
                     end
                     default: begin
                        // serial phase, mode three included
                        want.verdict = otap_pkg::V_SERIAL;
                        if (op == otap_pkg::OP_LOAD) begin
                           if (is_foreign) next = otap_pkg::SHARED_ENTRY;
                        end else if (!is_mine) begin
                           next = several ? {1'b0, tid} : otap_pkg::SHARED_ENTRY;
                        end
                     end
                  endcase
               end
               otap_pkg::OP_COMMIT: begin
                  want.verdict = otap_pkg::V_COMMIT;
                  if (several && sole) next = {1'b0, tid};
               end
               default: begin
                  want.verdict = otap_pkg::V_COMMIT;
                  if (several && is_foreign) next = otap_pkg::SHARED_ENTRY;
               end
            endcase

            owner_map[line]   = next;
            want.prior_shared = is_shared;
            want.prior_owner  = is_shared ? '0 : prior[otap_pkg::THREAD_W-1:0];
            want.new_shared   = next[otap_pkg::THREAD_W];
            want.new_owner    = next[otap_pkg::THREAD_W] ? '0 : next[otap_pkg::THREAD_W-1:0];
            awaited_outcomes.push_back(want);
         end
      end
      outstanding <= awaited_outcomes.size();
   end

endmodule

// ----- dv/ownership_table_access_policy_test.sv -----
// Testbench top: clock, reset, access request stimulus, response back-pressure and verdict.
`timescale 1ns / 1ps
module ownership_table_access_policy_test;

   localparam logic [otap_pkg::MODE_W-1:0] RM_SERIAL     = 2'd2;
   localparam logic [otap_pkg::MODE_W-1:0] RM_SERIAL_ALT = 2'd3;
   localparam int                          RANDOM_ITEMS  = 1200;

   // opcode in the low bits, sole_writer on top, as on req_tdata
   typedef struct packed {
      logic                          sole_writer;
      logic                          several_threads;
      logic [otap_pkg::MODE_W-1:0]   run_mode;
      logic [otap_pkg::THREAD_W-1:0] thread_id;
      logic [otap_pkg::INDEX_W-1:0]  entry_index;
      logic [otap_pkg::OPCODE_W-1:0] opcode;
   } access_request_type;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic [otap_pkg::REQ_W-1:0] req_tdata  = '0;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [otap_pkg::RSP_W-1:0] rsp_tdata;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic                       calm       = 1'b0;
   int                         failures;
   int                         outstanding;

   logic [otap_pkg::INDEX_W-1:0]  hot_lines   [8];
   logic [otap_pkg::THREAD_W-1:0] hot_threads [4];

   always #2 clock = ~clock;

   ownership_table_access_policy dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   owner_table_checker verify (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 18);
   end

   task automatic send_request(input logic [otap_pkg::OPCODE_W-1:0] op,
                               input logic [otap_pkg::INDEX_W-1:0]  idx,
                               input logic [otap_pkg::THREAD_W-1:0] tid,
                               input logic [otap_pkg::MODE_W-1:0]   mode,
                               input logic                          several,
                               input logic                          sole);
      access_request_type word;
      word = '{sole, several, mode, tid, idx, op};
      while (!calm && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         req_tdata  <= otap_pkg::REQ_W'($urandom);
         @(posedge clock);
      end
      req_tdata  <= word;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   initial begin
      logic [otap_pkg::OPCODE_W-1:0] op;
      logic [otap_pkg::INDEX_W-1:0]  idx;
      logic [otap_pkg::THREAD_W-1:0] tid;
      logic [otap_pkg::MODE_W-1:0]   mode;
      logic                          several, sole;

      hot_lines[0] = '0;
      hot_lines[1] = '1;
      hot_lines[2] = 12'd1;
      hot_lines[3] = 12'h800;
      for (int i = 4; i < 8; i++) hot_lines[i] = otap_pkg::INDEX_W'($urandom);
      hot_threads[0] = '0;
      hot_threads[1] = '1;
      hot_threads[2] = otap_pkg::THREAD_W'($urandom);
      hot_threads[3] = otap_pkg::THREAD_W'($urandom);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // ownership phase on a shared line
      send_request(otap_pkg::OP_LOAD,  12'd0, 6'd0, otap_pkg::RM_OWNERSHIP, 1'b1, 1'b0);
      send_request(otap_pkg::OP_STORE, 12'd0, 6'd0, otap_pkg::RM_OWNERSHIP, 1'b1, 1'b1);
      // serial store takes the line
      send_request(otap_pkg::OP_STORE, 12'd0, 6'd5, RM_SERIAL, 1'b1, 1'b0);
      send_request(otap_pkg::OP_LOAD,  12'd0, 6'd5, otap_pkg::RM_OWNERSHIP, 1'b0, 1'b0);
      send_request(otap_pkg::OP_LOAD,  12'd0, 6'd6, otap_pkg::RM_OWNERSHIP, 1'b1, 1'b0);
      send_request(otap_pkg::OP_STORE, 12'd0, 6'd5, otap_pkg::RM_OWNERSHIP, 1'b1, 1'b0);
      send_request(otap_pkg::OP_STORE, 12'd0, 6'd6, otap_pkg::RM_OWNERSHIP, 1'b1, 1'b0);
      send_request(otap_pkg::OP_LOAD,  12'd0, 6'd6, otap_pkg::RM_BUFFERED, 1'b1, 1'b1);
      send_request(otap_pkg::OP_STORE, 12'd0, 6'd6, otap_pkg::RM_BUFFERED, 1'b0, 1'b0);
      // serial load: own line kept, foreign line goes shared
      send_request(otap_pkg::OP_LOAD,  12'd0, 6'd5, RM_SERIAL, 1'b1, 1'b0);
      send_request(otap_pkg::OP_LOAD,  12'd0, 6'd9, RM_SERIAL, 1'b1, 1'b0);
      // serial store with one live thread leaves the line shared
      send_request(otap_pkg::OP_STORE, 12'd0, 6'd7, RM_SERIAL, 1'b0, 1'b0);
      // mode three acts as serial
      send_request(otap_pkg::OP_STORE, 12'hfff, 6'd63, RM_SERIAL_ALT, 1'b1, 1'b0);
      send_request(otap_pkg::OP_STORE, 12'hfff, 6'd1, RM_SERIAL, 1'b0, 1'b1);
      // commit take ownership, several/sole flag combinations 11, 10 and 01
      send_request(otap_pkg::OP_COMMIT, 12'hfff, 6'd63, otap_pkg::RM_BUFFERED, 1'b1, 1'b1);
      send_request(otap_pkg::OP_COMMIT, 12'hfff, 6'd2, otap_pkg::RM_OWNERSHIP, 1'b1, 1'b0);
      send_request(otap_pkg::OP_COMMIT, 12'hfff, 6'd2, RM_SERIAL_ALT, 1'b0, 1'b1);
      // read-log release: own line, one live thread, foreign line, shared line
      send_request(otap_pkg::OP_RELEASE, 12'hfff, 6'd63, otap_pkg::RM_BUFFERED, 1'b1, 1'b0);
      send_request(otap_pkg::OP_RELEASE, 12'hfff, 6'd2, otap_pkg::RM_BUFFERED, 1'b0, 1'b0);
      send_request(otap_pkg::OP_RELEASE, 12'hfff, 6'd2, RM_SERIAL, 1'b1, 1'b1);
      send_request(otap_pkg::OP_RELEASE, 12'hfff, 6'd2, otap_pkg::RM_OWNERSHIP, 1'b1, 1'b0);
      send_request(otap_pkg::OP_LOAD,  12'hfff, 6'd63, RM_SERIAL_ALT, 1'b1, 1'b1);
      send_request(otap_pkg::OP_COMMIT, 12'h555, 6'h2a, RM_SERIAL_ALT, 1'b1, 1'b1);
      send_request(otap_pkg::OP_STORE, 12'h555, 6'h15, otap_pkg::RM_OWNERSHIP, 1'b1, 1'b1);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= 500 && n < 700);
         if ($urandom_range(99) < 85) begin
            // a few hot lines and threads so ownership moves back and forth
            op      = otap_pkg::OPCODE_W'($urandom_range(3));
            mode    = otap_pkg::MODE_W'($urandom_range(3));
            idx     = hot_lines[$urandom_range(7)];
            tid     = hot_threads[$urandom_range(3)];
            several = $urandom_range(99) < 75;
            sole    = $urandom_range(99) < 70;
         end else begin
            op      = otap_pkg::OPCODE_W'($urandom);
            mode    = otap_pkg::MODE_W'($urandom);
            idx     = otap_pkg::INDEX_W'($urandom);
            tid     = otap_pkg::THREAD_W'($urandom);
            several = 1'($urandom);
            sole    = 1'($urandom);
         end
         send_request(op, idx, tid, mode, several, sole);
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("ownership_table_access_policy regression: pass");
      end else begin
         $display("ownership_table_access_policy regression: fail");
      end
      $finish;
   end

   // clearing pass plus every request at its slowest, many times over
   initial begin
      #800_000;
      $display("ownership_table_access_policy regression: fail");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/otap_pkg.sv
rtl/core/otap_ram.sv
rtl/core/otap_ctrl.sv
rtl/core/otap_dp.sv
rtl/core/ownership_table_access_policy.sv
dv/owner_table_checker.sv
dv/ownership_table_access_policy_test.sv
